// ----- hw/rtl/s2cpv_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// s2cpv_pkg
// Shared types, constants and arithmetic helpers of the spherical to
// cartesian position/velocity converter.
// ----------------------------------------------------------------------------
package s2cpv_pkg;

  localparam int FIELD_W       = 32;
  localparam int CW            = 34;
  localparam int TRIG_FRAC     = 30;
  localparam int DEF_DATA_W    = 32;
  localparam int DEF_FRAC_BITS = 16;
  localparam int DEF_STAGES    = 24;
  localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sh026DD3B6A;
  localparam logic signed [CW-1:0] TRIG_ONE    = 34'sh040000000;

  typedef struct packed {
    logic                      kind;
    logic signed [FIELD_W-1:0] a;
    logic signed [FIELD_W-1:0] b;
    logic signed [FIELD_W-1:0] c;
    logic signed [FIELD_W-1:0] d;
    logic signed [FIELD_W-1:0] e;
    logic signed [FIELD_W-1:0] f;
  } vec_t;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
    logic [1:0]           q;
  } rot_t;

  typedef struct packed {
    logic signed [CW-1:0] c;
    logic signed [CW-1:0] s;
  } trig_t;

  function automatic logic [31:0] atan_lut(input int k);
    logic [31:0] v;
    case (k)
      0:  v = 32'h20000000;  1: v = 32'h12E4051E;  2: v = 32'h09FB385B;
      3:  v = 32'h051111D4;  4: v = 32'h028B0D43;  5: v = 32'h0145D7E1;
      6:  v = 32'h00A2F61E;  7: v = 32'h00517C55;  8: v = 32'h0028BE53;
      9:  v = 32'h00145F2F; 10: v = 32'h000A2F98; 11: v = 32'h000517CC;
      12: v = 32'h00028BE6; 13: v = 32'h000145F3; 14: v = 32'h0000A2FA;
      15: v = 32'h0000517D; 16: v = 32'h000028BE; 17: v = 32'h0000145F;
      18: v = 32'h00000A30; 19: v = 32'h00000518; 20: v = 32'h0000028C;
      21: v = 32'h00000146; 22: v = 32'h000000A3; 23: v = 32'h00000051;
      24: v = 32'h00000029; 25: v = 32'h00000014; 26: v = 32'h0000000A;
      27: v = 32'h00000005; 28: v = 32'h00000003; 29: v = 32'h00000001;
      30: v = 32'h00000001;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

  // split angle into quadrant and residual, load the rotator
  function automatic rot_t rot_load(input logic [31:0] th);
    rot_t        r;
    logic [31:0] sh;
    logic [31:0] res;
    sh  = th + 32'h20000000;
    res = th - {sh[31:30], 30'd0};
    r.x = CORDIC_GAIN;
    r.y = '0;
    r.z = CW'(signed'(res));
    r.q = sh[31:30];
    return r;
  endfunction

  function automatic rot_t rot_step(input rot_t r, input int k);
    rot_t                 n;
    logic signed [CW-1:0] t;
    t   = CW'(atan_lut(k));
    n.q = r.q;
    if (!r.z[CW-1]) begin
      n.x = r.x - (r.y >>> k);
      n.y = r.y + (r.x >>> k);
      n.z = r.z - t;
    end else begin
      n.x = r.x + (r.y >>> k);
      n.y = r.y - (r.x >>> k);
      n.z = r.z + t;
    end
    return n;
  endfunction

  function automatic logic signed [CW-1:0] clamp_trig(input logic signed [CW-1:0] v);
    if (v > TRIG_ONE) return TRIG_ONE;
    if (v < -TRIG_ONE) return -TRIG_ONE;
    return v;
  endfunction

  function automatic trig_t rot_map(input rot_t r);
    trig_t t;
    case (r.q)
      2'd0:    begin t.c = r.x;  t.s = r.y;  end
      2'd1:    begin t.c = -r.y; t.s = r.x;  end
      2'd2:    begin t.c = -r.x; t.s = -r.y; end
      default: begin t.c = r.y;  t.s = -r.x; end
    endcase
    t.c = clamp_trig(t.c);
    t.s = clamp_trig(t.s);
    return t;
  endfunction

  // rounded product: floor((a*b + 2^(s-1)) / 2^s)
  function automatic logic signed [63:0] mulr(input logic signed [CW-1:0] a,
                                              input logic signed [CW-1:0] b,
                                              input int s);
    logic signed [2*CW-1:0] p;
    logic signed [2*CW-1:0] h;
    p = a * b;
    h = (p + ((2*CW)'(1) <<< (s - 1))) >>> s;
    return h[63:0];
  endfunction

  function automatic logic signed [FIELD_W-1:0] sat(input logic signed [63:0] v,
                                                    input int w);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    logic signed [63:0] r;
    hi = (64'sd1 <<< (w - 1)) - 64'sd1;
    lo = -hi - 64'sd1;
    r  = v;
    if (v > hi) r = hi;
    if (v < lo) r = lo;
    return r[FIELD_W-1:0];
  endfunction

endpackage

// ----- hw/rtl/s2cpv_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// s2cpv_in_if
// Input channel: kind flag and six state-vector components.
// ----------------------------------------------------------------------------
interface s2cpv_in_if;
  logic               valid;
  logic               ready;
  logic               kind;
  logic signed [31:0] comp_a;
  logic signed [31:0] comp_b;
  logic signed [31:0] comp_c;
  logic signed [31:0] comp_d;
  logic signed [31:0] comp_e;
  logic signed [31:0] comp_f;
  modport source (output valid, kind, comp_a, comp_b, comp_c, comp_d, comp_e, comp_f,
                  input ready);
  modport sink (input valid, kind, comp_a, comp_b, comp_c, comp_d, comp_e, comp_f,
                output ready);
endinterface

// ----------------------------------------------------------------------------
// s2cpv_out_if
// Output channel: cartesian position and velocity.
// ----------------------------------------------------------------------------
interface s2cpv_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  logic signed [31:0] vel_x;
  logic signed [31:0] vel_y;
  logic signed [31:0] vel_z;
  modport source (output valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, input ready);
  modport sink (input valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, output ready);
endinterface

// ----- hw/rtl/spherical_to_cartesian_pv.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spherical_to_cartesian_pv
// Converts spherical state vectors to cartesian position and velocity.
//
// in_i carries one state vector per beat: kind, then six components. A
// spherical vector (kind 0) holds radius, right ascension, declination and
// their rates; a cartesian one (kind 1) is passed through, saturated.
// out_o carries pos_x/y/z and vel_x/y/z, Q.FRAC_BITS, saturated.
// The pipeline holds one input register, one unrolled
// CORDIC stage per rotation (both angles side by side), a quadrant map
// stage, three multiplier stages and the output register with the sums.
// Throughput is one beat per cycle unless out_o stalls; the whole pipeline
// advances as one when the output register is empty or taken, so a stall
// at out_o holds every stage in place and drops nothing; in_i.ready
// falls in that cycle. Reset clears all valid bits; no other state is kept.
// ----------------------------------------------------------------------------
module spherical_to_cartesian_pv
  import s2cpv_pkg::*;
#(
  parameter int DATA_WIDTH    = DEF_DATA_W,
  parameter int FRAC_BITS     = DEF_FRAC_BITS,
  parameter int CORDIC_STAGES = DEF_STAGES
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  s2cpv_in_if.sink    in_i,
  s2cpv_out_if.source out_o
);

  localparam int OUT_W = (DATA_WIDTH < 32) ? DATA_WIDTH : 32;
  localparam int N     = CORDIC_STAGES;

  logic adv;

  logic  cv_q [N+1];
  vec_t  cvec_q [N+1];
  rot_t  ra_q [N+1];
  rot_t  rd_q [N+1];

  logic  mv_q;
  vec_t  mvec_q;
  trig_t ta_q, td_q;

  logic                 v1_q;
  vec_t                 vec1_q;
  trig_t                ta1_q;
  logic signed [CW-1:0] rc1_q, rs1_q, rdc1_q;
  logic signed [63:0]   rdsd1_q;

  logic                 v2_q;
  vec_t                 vec2_q;
  logic signed [CW-1:0] px2_q, py2_q, u2_q, w2_q, rs2_q;
  logic signed [63:0]   rdcca2_q, rdcsa2_q, rcdd2_q, rdsd2_q;

  logic                 v3_q;
  vec_t                 vec3_q;
  logic signed [CW-1:0] px3_q, py3_q, rs3_q;
  logic signed [63:0]   t1_q, t2_q, t3_q, t4_q;
  logic signed [63:0]   rdcca3_q, rdcsa3_q, rcdd3_q, rdsd3_q;

  logic                     ov_q;
  logic signed [FIELD_W-1:0] px_q, py_q, pz_q, vx_q, vy_q, vz_q;
  logic signed [63:0]        vx_d, vy_d, vz_d;

  assign adv        = !ov_q || out_o.ready;
  assign in_i.ready = adv;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cv_q[0] <= 1'b0;
    end else if (adv) begin
      cv_q[0] <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      cvec_q[0] <= '{kind: in_i.kind, a: in_i.comp_a, b: in_i.comp_b, c: in_i.comp_c,
                     d: in_i.comp_d, e: in_i.comp_e, f: in_i.comp_f};
      ra_q[0]   <= rot_load(in_i.comp_b);
      rd_q[0]   <= rot_load(in_i.comp_c);
    end
  end

  // CORDIC rotation stages
  for (genvar k = 0; k < N; k++) begin : g_rot
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        cv_q[k+1] <= 1'b0;
      end else if (adv) begin
        cv_q[k+1] <= cv_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        cvec_q[k+1] <= cvec_q[k];
        ra_q[k+1]   <= rot_step(ra_q[k], k);
        rd_q[k+1]   <= rot_step(rd_q[k], k);
      end
    end
  end

  // quadrant map, first products, second products, rate products
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mv_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      ov_q <= 1'b0;
    end else if (adv) begin
      mv_q <= cv_q[N];
      v1_q <= mv_q;
      v2_q <= v1_q;
      v3_q <= v2_q;
      ov_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      mvec_q <= cvec_q[N];
      ta_q   <= rot_map(ra_q[N]);
      td_q   <= rot_map(rd_q[N]);

      vec1_q  <= mvec_q;
      ta1_q   <= ta_q;
      rc1_q   <= CW'(mulr(CW'(mvec_q.a), td_q.c, TRIG_FRAC));
      rs1_q   <= CW'(mulr(CW'(mvec_q.a), td_q.s, TRIG_FRAC));
      rdc1_q  <= CW'(mulr(CW'(mvec_q.d), td_q.c, TRIG_FRAC));
      rdsd1_q <= mulr(CW'(mvec_q.d), td_q.s, TRIG_FRAC);

      vec2_q   <= vec1_q;
      px2_q    <= CW'(mulr(rc1_q, ta1_q.c, TRIG_FRAC));
      py2_q    <= CW'(mulr(rc1_q, ta1_q.s, TRIG_FRAC));
      u2_q     <= CW'(mulr(rs1_q, ta1_q.c, TRIG_FRAC));
      w2_q     <= CW'(mulr(rs1_q, ta1_q.s, TRIG_FRAC));
      rs2_q    <= rs1_q;
      rdcca2_q <= mulr(rdc1_q, ta1_q.c, TRIG_FRAC);
      rdcsa2_q <= mulr(rdc1_q, ta1_q.s, TRIG_FRAC);
      rcdd2_q  <= mulr(rc1_q, CW'(vec1_q.f), FRAC_BITS);
      rdsd2_q  <= rdsd1_q;

      vec3_q   <= vec2_q;
      px3_q    <= px2_q;
      py3_q    <= py2_q;
      rs3_q    <= rs2_q;
      t1_q     <= mulr(py2_q, CW'(vec2_q.e), FRAC_BITS);
      t2_q     <= mulr(u2_q, CW'(vec2_q.f), FRAC_BITS);
      t3_q     <= mulr(px2_q, CW'(vec2_q.e), FRAC_BITS);
      t4_q     <= mulr(w2_q, CW'(vec2_q.f), FRAC_BITS);
      rdcca3_q <= rdcca2_q;
      rdcsa3_q <= rdcsa2_q;
      rcdd3_q  <= rcdd2_q;
      rdsd3_q  <= rdsd2_q;
    end
  end

  // sums, saturation and cartesian bypass
  assign vx_d = rdcca3_q - t1_q - t2_q;
  assign vy_d = t3_q - t4_q + rdcsa3_q;
  assign vz_d = rcdd3_q + rdsd3_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      if (vec3_q.kind) begin
        px_q <= sat(64'(vec3_q.a), OUT_W);
        py_q <= sat(64'(vec3_q.b), OUT_W);
        pz_q <= sat(64'(vec3_q.c), OUT_W);
        vx_q <= sat(64'(vec3_q.d), OUT_W);
        vy_q <= sat(64'(vec3_q.e), OUT_W);
        vz_q <= sat(64'(vec3_q.f), OUT_W);
      end else begin
        px_q <= sat(64'(px3_q), OUT_W);
        py_q <= sat(64'(py3_q), OUT_W);
        pz_q <= sat(64'(rs3_q), OUT_W);
        vx_q <= sat(vx_d, OUT_W);
        vy_q <= sat(vy_d, OUT_W);
        vz_q <= sat(vz_d, OUT_W);
      end
    end
  end

  assign out_o.valid = ov_q;
  assign out_o.pos_x = px_q;
  assign out_o.pos_y = py_q;
  assign out_o.pos_z = pz_q;
  assign out_o.vel_x = vx_q;
  assign out_o.vel_y = vy_q;
  assign out_o.vel_z = vz_q;

`ifndef SYNTH
  a_last_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v3_q && adv) |=> ov_q)
    else $error("pipeline beat lost before output register");

  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> ($stable(v1_q) && $stable(v2_q) && $stable(v3_q) && $stable(mv_q)))
    else $error("pipeline moved during stall");

  a_trig_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mv_q |-> (ta_q.c <= TRIG_ONE && ta_q.c >= -TRIG_ONE &&
              td_q.s <= TRIG_ONE && td_q.s >= -TRIG_ONE))
    else $error("sine or cosine out of range");

  a_ready_follows_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && !out_o.ready) |-> !in_i.ready)
    else $error("input taken while output stalled");
`endif

endmodule
